// ===== src/i2d_pkg.sv =====
// Shared types and constants for the 64-bit binary to decimal ASCII converter.
package i2d_pkg;

    localparam int NUM_DIGITS    = 20;
    localparam int BITS_PER_STEP = 4;
    localparam int DABBLE_STEPS  = 64 / BITS_PER_STEP;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    // One classified conversion job handed from the front to the back.
    typedef struct packed {
        logic        neg;
        logic [63:0] mag;
        logic [4:0]  limit;
    } job_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DABBLE,
        ST_SIZE,
        ST_EMIT
    } back_state_t;

endpackage

// ===== src/i2d_front.sv =====
// Front end: accepts an input item, takes sign and magnitude, hands a job on.
module i2d_front (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic         in_command,
    input  logic [63:0]  in_value,
    input  logic [4:0]   in_limit,
    output logic         job_valid,
    input  logic         job_ready,
    output i2d_pkg::job_t job
);
    import i2d_pkg::*;

    logic valid_reg;
    logic valid_next;
    job_t job_reg;
    job_t job_next;
    logic neg;

    assign in_ready  = !valid_reg || job_ready;
    assign job_valid = valid_reg;
    assign job       = job_reg;

    always_comb
    begin
        // Signed reading only when command asks for it and the top bit is set.
        neg            = !in_command && in_value[63];
        job_next.neg   = neg;
        job_next.mag   = neg ? (~in_value + 64'd1) : in_value;
        job_next.limit = in_limit;
        valid_next     = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (job_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            job_reg <= job_next;
        end
    end

endmodule

// ===== src/i2d_fifo.sv =====
// Two-entry job queue between the front and back ends.
module i2d_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  i2d_pkg::job_t push_job,
    output logic          pop_valid,
    input  logic          pop_ready,
    output i2d_pkg::job_t pop_job
);
    import i2d_pkg::*;

    job_t       mem [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_job    = mem[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== src/i2d_back.sv =====
// Back end: double-dabble conversion, length check and character emission.
module i2d_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          job_valid,
    output logic          job_ready,
    input  i2d_pkg::job_t job,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    out_char,
    output logic          out_last,
    output logic          out_too_long,
    output logic [4:0]    out_length
);
    import i2d_pkg::*;

    localparam int BCD_W = NUM_DIGITS * 4;

    back_state_t state_reg, state_next;
    logic [63:0]      bin_reg, bin_next;
    logic [BCD_W-1:0] bcd_reg, bcd_next;
    logic [3:0]       step_reg, step_next;
    logic             neg_reg, neg_next;
    logic [4:0]       limit_reg, limit_next;
    logic [4:0]       total_reg, total_next;
    logic [4:0]       idx_reg, idx_next;
    logic             sign_reg, sign_next;
    logic             err_reg, err_next;

    logic             ov_reg, ov_next;
    logic [7:0]       char_reg, char_next;
    logic             last_reg, last_next;
    logic             tl_reg, tl_next;
    logic [4:0]       len_reg, len_next;

    logic             slot_free;
    logic [BCD_W+63:0] dabbled;
    logic [4:0]       ndig;
    logic [4:0]       total;
    logic [3:0]       digit;

    // Four shift-and-correct steps of the double-dabble recurrence.
    function automatic logic [BCD_W+63:0] dabble4(input logic [BCD_W+63:0] v);
        logic [BCD_W+63:0] w;
        w = v;
        for (int s = 0; s < BITS_PER_STEP; s++)
        begin
            for (int d = 0; d < NUM_DIGITS; d++)
            begin
                if (w[64 + d*4 +: 4] >= 4'd5)
                begin
                    w[64 + d*4 +: 4] = w[64 + d*4 +: 4] + 4'd3;
                end
            end
            w = {w[BCD_W+62:0], 1'b0};
        end
        return w;
    endfunction

    assign slot_free    = !ov_reg || out_ready;
    assign job_ready    = (state_reg == ST_IDLE);
    assign out_valid    = ov_reg;
    assign out_char     = char_reg;
    assign out_last     = last_reg;
    assign out_too_long = tl_reg;
    assign out_length   = len_reg;
    assign dabbled      = dabble4({bcd_reg, bin_reg});

    always_comb
    begin
        // Highest nonzero digit sets the digit count; zero still gives one digit.
        ndig = 5'd1;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[i*4 +: 4] != 4'd0)
            begin
                ndig = 5'(i + 1);
            end
        end
        total = ndig + {4'd0, neg_reg};
        digit = 4'd0;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (idx_reg == 5'(i))
            begin
                digit = bcd_reg[i*4 +: 4];
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        bin_next   = bin_reg;
        bcd_next   = bcd_reg;
        step_next  = step_reg;
        neg_next   = neg_reg;
        limit_next = limit_reg;
        total_next = total_reg;
        idx_next   = idx_reg;
        sign_next  = sign_reg;
        err_next   = err_reg;
        ov_next    = out_ready ? 1'b0 : ov_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        tl_next    = tl_reg;
        len_next   = len_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    bin_next   = job.mag;
                    bcd_next   = '0;
                    step_next  = 4'd0;
                    neg_next   = job.neg;
                    limit_next = job.limit;
                    state_next = ST_DABBLE;
                end
            end
            ST_DABBLE:
            begin
                bcd_next  = dabbled[BCD_W+63:64];
                bin_next  = dabbled[63:0];
                step_next = step_reg + 4'd1;
                if (step_reg == 4'(DABBLE_STEPS - 1))
                begin
                    state_next = ST_SIZE;
                end
            end
            ST_SIZE:
            begin
                total_next = total;
                idx_next   = ndig - 5'd1;
                sign_next  = neg_reg;
                err_next   = (total > limit_reg);
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    ov_next = 1'b1;
                    if (err_reg)
                    begin
                        char_next  = 8'd0;
                        last_next  = 1'b1;
                        tl_next    = 1'b1;
                        len_next   = 5'd0;
                        state_next = ST_IDLE;
                    end
                    else if (sign_reg)
                    begin
                        char_next = CHAR_MINUS;
                        last_next = 1'b0;
                        tl_next   = 1'b0;
                        len_next  = 5'd0;
                        sign_next = 1'b0;
                    end
                    else
                    begin
                        char_next = CHAR_ZERO + {4'd0, digit};
                        tl_next   = 1'b0;
                        last_next = (idx_reg == 5'd0);
                        len_next  = (idx_reg == 5'd0) ? total_reg : 5'd0;
                        idx_next  = idx_reg - 5'd1;
                        if (idx_reg == 5'd0)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg   <= bin_next;
        bcd_reg   <= bcd_next;
        step_reg  <= step_next;
        neg_reg   <= neg_next;
        limit_reg <= limit_next;
        total_reg <= total_next;
        idx_reg   <= idx_next;
        sign_reg  <= sign_next;
        err_reg   <= err_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
        tl_reg    <= tl_next;
        len_reg   <= len_next;
    end

endmodule

// ===== src/int64_to_decimal_ascii.sv =====
// Top level of the 64-bit binary to decimal ASCII converter.
//
// Each input item carries a 64-bit value (tuser selects signed when 0, unsigned when 1)
// and a 5-bit length limit; the block returns the decimal text one character per
// output item, most significant first, with a leading '-' for negative signed values.
// The final character carries tlast and the total length. When the text would exceed
// the limit, a single item with tuser (too long) and tlast set and zero data is sent.
// The front end takes sign and magnitude and buffers up to two jobs in a small queue,
// so new items are accepted while a conversion runs. The back end converts with a
// double-dabble unit that handles four bits per cycle. One item occupies it while it loads
// the job, converts it, sizes the text and emits the output items (1..20 characters, or
// the single error item); output stalls hold the emission.
module int64_to_decimal_ascii (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [71:0]  s_tdata,   // [63:0] value, [68:64] dest_limit, rest zero
    input  logic         s_tuser,   // [0] command
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [15:0]  m_tdata,   // [7:0] text_char, [12:8] text_length, rest zero
    output logic         m_tuser,   // [0] too_long
    output logic         m_tlast
);
    import i2d_pkg::*;

    logic       front_valid;
    logic       front_ready;
    job_t       front_job;
    logic       queue_valid;
    logic       queue_ready;
    job_t       queue_job;
    logic [7:0] text_char;
    logic [4:0] text_length;

    i2d_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_command (s_tuser),
        .in_value   (s_tdata[63:0]),
        .in_limit   (s_tdata[68:64]),
        .job_valid  (front_valid),
        .job_ready  (front_ready),
        .job        (front_job)
    );

    i2d_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_job   (front_job),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_job    (queue_job)
    );

    i2d_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (queue_valid),
        .job_ready    (queue_ready),
        .job          (queue_job),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_char     (text_char),
        .out_last     (m_tlast),
        .out_too_long (m_tuser),
        .out_length   (text_length)
    );

    assign m_tdata = {3'd0, text_length, text_char};

endmodule

// ===== dv/tb.sv =====
// Testbench for the 64-bit binary to decimal ASCII converter: directed, random and stall tests.
module tb;
    import i2d_pkg::*;

    localparam logic CMD_SIGNED   = 1'b0;
    localparam logic CMD_UNSIGNED = 1'b1;
    localparam int unsigned CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       too_long;
        logic [4:0] len;
    } text_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;    // [63:0] value, [68:64] dest_limit, rest zero
    logic        s_tuser = 1'b0;  // [0] command
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // [7:0] text_char, [12:8] text_length, rest zero
    logic        m_tuser;         // [0] too_long
    logic        m_tlast;

    text_item_t  text_expected[$];
    logic [7:0]  text_chars[$];
    int          src_idle_pct = 0;
    int          sink_stall_pct = 0;
    int          hold_left = 0;
    int          errors = 0;
    int unsigned cycle_count = 0;

    int64_to_decimal_ascii u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #4 clk = ~clk;

    // Fill text_chars with the decimal text of raw, most significant first.
    function automatic void render_decimal(input logic cmd, input logic [63:0] raw);
        logic        neg;
        logic [63:0] mag;
        logic [7:0]  digit;
        neg = (cmd == CMD_SIGNED) && raw[63];
        mag = neg ? (~raw + 64'd1) : raw;
        text_chars.delete();
        do
        begin
            digit = 8'(mag % 64'd10);
            text_chars.push_front(CHAR_ZERO + digit);
            mag = mag / 64'd10;
        end
        while (mag != 64'd0);
        if (neg)
            text_chars.push_front(CHAR_MINUS);
    endfunction

    function automatic void predict_text(input logic cmd, input logic [63:0] raw,
                                         input logic [4:0] limit);
        text_item_t item;
        int         n;
        render_decimal(cmd, raw);
        n = text_chars.size();
        if (n > limit)
        begin
            item = '{ch: 8'd0, last: 1'b1, too_long: 1'b1, len: 5'd0};
            text_expected.push_back(item);
        end
        else
        begin
            for (int k = 0; k < n; k++)
            begin
                item.ch       = text_chars[k];
                item.last     = (k == n - 1);
                item.too_long = 1'b0;
                item.len      = (k == n - 1) ? 5'(n) : 5'd0;
                text_expected.push_back(item);
            end
        end
    endfunction

    // Entered and left at a falling edge.
    task automatic send_item(input logic cmd, input logic [63:0] raw, input logic [4:0] limit);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, limit, raw};
        s_tuser  <= cmd;
        do
            @(posedge clk);
        while (!s_tready);
        predict_text(cmd, raw, limit);
        @(negedge clk);
    endtask

    task automatic test_directed();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        send_item(CMD_SIGNED,   64'd0, 5'd1);
        send_item(CMD_UNSIGNED, 64'd0, 5'd0);
        send_item(CMD_UNSIGNED, 64'hFFFF_FFFF_FFFF_FFFF, 5'd20);
        send_item(CMD_UNSIGNED, 64'hFFFF_FFFF_FFFF_FFFF, 5'd19);
        send_item(CMD_SIGNED,   64'hFFFF_FFFF_FFFF_FFFF, 5'd2);
        send_item(CMD_SIGNED,   64'hFFFF_FFFF_FFFF_FFFF, 5'd1);
        send_item(CMD_SIGNED,   64'h8000_0000_0000_0000, 5'd20);
        send_item(CMD_SIGNED,   64'h8000_0000_0000_0000, 5'd19);
        send_item(CMD_UNSIGNED, 64'h8000_0000_0000_0000, 5'd31);
        send_item(CMD_SIGNED,   64'h7FFF_FFFF_FFFF_FFFF, 5'd19);
        send_item(CMD_UNSIGNED, 64'd9999999999999999999, 5'd31);
        send_item(CMD_UNSIGNED, 64'd10000000000000000000, 5'd20);
        send_item(CMD_SIGNED,   64'd9, 5'd1);
        send_item(CMD_SIGNED,   64'd10, 5'd1);
        send_item(CMD_UNSIGNED, 64'd10, 5'd2);
        send_item(CMD_SIGNED,   -64'sd10, 5'd3);
        send_item(CMD_SIGNED,   64'h5555_5555_5555_5555, 5'd31);
        send_item(CMD_UNSIGNED, 64'hAAAA_AAAA_AAAA_AAAA, 5'd31);
        send_item(CMD_SIGNED,   64'hAAAA_AAAA_AAAA_AAAA, 5'd0);
        send_item(CMD_UNSIGNED, 64'd1, 5'd31);
    endtask

    task automatic test_random_traffic(input int count, input int src_pct, input int sink_pct);
        logic        cmd;
        logic [63:0] raw;
        logic [63:0] pow;
        int          lim;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        repeat (count)
        begin
            cmd = 1'($urandom_range(0, 1));
            raw = {$urandom, $urandom};
            case ($urandom_range(0, 3))
                1: raw = raw >> $urandom_range(0, 63);
                2: raw = ~(raw >> $urandom_range(1, 63)) + 64'd1;
                3:
                begin
                    // land on or just below a power of ten
                    pow = 64'd1;
                    repeat ($urandom_range(0, 19))
                        pow = pow * 64'd10;
                    raw = pow - 64'($urandom_range(0, 1));
                end
                default: ;
            endcase
            if ($urandom_range(0, 2) == 0)
                lim = int'($urandom_range(0, 31));
            else
            begin
                // hover around the text length to hit the too-long boundary
                render_decimal(cmd, raw);
                lim = text_chars.size() + int'($urandom_range(0, 3)) - 1;
                if (lim > 31)
                    lim = 31;
            end
            send_item(cmd, raw, 5'(lim));
        end
    endtask

    task automatic test_output_holdoff();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_left      = 400;
        repeat (16)
            send_item(1'($urandom_range(0, 1)), {$urandom, $urandom}, 5'd31);
    endtask

    // Result sink: random stalls, plus a long hold-off when requested.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    task automatic report(input string field, input logic [7:0] want, input logic [7:0] got);
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
        errors++;
    endtask

    always @(posedge clk)
    begin
        text_item_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (text_expected.size() == 0)
            begin
                $display("%0t: unexpected item: expected none, actual data %0h user %b last %b",
                         $time, m_tdata, m_tuser, m_tlast);
                errors++;
            end
            else
            begin
                want = text_expected.pop_front();
                if (m_tdata[7:0] !== want.ch)
                    report("text_char", want.ch, m_tdata[7:0]);
                if (m_tdata[12:8] !== want.len)
                    report("text_length", 8'(want.len), 8'(m_tdata[12:8]));
                if (m_tuser !== want.too_long)
                    report("too_long", 8'(want.too_long), 8'(m_tuser));
                if (m_tlast !== want.last)
                    report("is_last", 8'(want.last), 8'(m_tlast));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d items still expected", $time, text_expected.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        test_directed();
        test_random_traffic(85, 0, 0);
        test_random_traffic(85, 84, 0);
        test_random_traffic(85, 0, 84);
        test_random_traffic(85, 17, 17);
        test_output_holdoff();

        s_tvalid <= 1'b0;
        while (text_expected.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
src/i2d_pkg.sv
src/i2d_front.sv
src/i2d_fifo.sv
src/i2d_back.sv
src/int64_to_decimal_ascii.sv
dv/tb.sv
